### hw/rtl/uers_pkg.sv
// Shared types and constants for the ultrasonic echo range scanner.
// Holds the request structs, register indexes and the cm conversion constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uers_pkg;

  localparam int unsigned SensorCount = 10;
  localparam int unsigned SensorW     = 4;
  localparam int unsigned TimerW      = 16;
  localparam int unsigned CountW      = 8;
  localparam int unsigned DistW       = 11;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CfgTrigTicks  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEchoTmo    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRestTicks  = 2'd2;

  localparam logic [CountW-1:0] TrigTicksRst = 8'd1;
  localparam logic [CountW-1:0] EchoTmoRst   = 8'd50;
  localparam logic [CountW-1:0] RestTicksRst = 8'd10;

  localparam logic KindTick = 1'b0;
  localparam logic KindPoll = 1'b1;

  // width / 58 == (width * CmRecip) >> CmShift for any 16-bit width
  localparam int unsigned CmShift = 22;
  localparam int unsigned RecipW  = 17;
  localparam logic [RecipW-1:0] CmRecip = 17'd72316;

  typedef struct packed {
    logic              kind;
    logic [SensorW-1:0] sensor;
    logic              echo_level;
    logic [TimerW-1:0] timer_now;
  } in_req_t;

  typedef struct packed {
    logic [SensorW-1:0] sensor_id;
    logic               trigger_level;
    logic               distance_valid;
    logic [DistW-1:0]   range_cm;
  } out_req_t;

endpackage

`default_nettype wire

### hw/rtl/ultrasonic_echo_range_scanner_unit.sv
// A request passes the input reg, the state reg and the conversion/result reg before its
// result is valid. Throughput: one request per cycle while the pipe is not held; tick
// requests give no result. The whole pipe holds while a result waits under out_stall_i.
// Reset (async, active low) puts every sensor idle with zero countdown and loads
// register defaults: trigger 1, echo timeout 50, rest 10 ticks.
// Depends on uers_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_range_scanner_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [uers_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [uers_pkg::CountW-1:0]  cfg_data_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire uers_pkg::in_req_t      in_req_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output uers_pkg::out_req_t          out_req_o
);
  import uers_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhRise = 2'd2;
  localparam logic [1:0] PhFall = 2'd3;

  logic [CountW-1:0] trig_ticks_q, echo_tmo_q, rest_ticks_q;

  logic [SensorCount-1:0][1:0]        phase_q, phase_d;
  logic [SensorCount-1:0][CountW-1:0] cnt_q, cnt_d;
  logic [SensorCount-1:0]             prior_q, prior_d;
  logic [SensorCount-1:0]             trig_q, trig_d;
  logic [SensorCount-1:0][TimerW-1:0] rise_q, rise_d;

  logic    adv;
  logic    s1_vld_q;
  in_req_t s1_q;

  logic               s2_vld_q, s2_vld_d;
  logic [SensorW-1:0] s2_id_q;
  logic               s2_trig_q, s2_trig_d;
  logic               s2_dv_q, s2_dv_d;
  logic [TimerW-1:0]  s2_width_q, s2_width_d;

  logic                     out_vld_q;
  out_req_t                 out_q;
  logic [TimerW+RecipW-1:0] prod;

  assign adv        = ~(out_vld_q & out_stall_i);
  assign in_stall_o = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TrigTicksRst;
      echo_tmo_q   <= EchoTmoRst;
      rest_ticks_q <= RestTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTrigTicks: trig_ticks_q <= cfg_data_i;
        CfgEchoTmo:   echo_tmo_q   <= cfg_data_i;
        CfgRestTicks: rest_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_q <= in_req_i;
    end
  end

  // stage 2: per-sensor sequencer update
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    prior_d    = prior_q;
    trig_d     = trig_q;
    rise_d     = rise_q;
    s2_vld_d   = 1'b0;
    s2_trig_d  = 1'b0;
    s2_dv_d    = 1'b0;
    s2_width_d = '0;
    if (s1_vld_q) begin
      if (s1_q.kind == KindTick) begin
        for (int i = 0; i < SensorCount; i++) begin
          if (cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - 1'b1;
          end
        end
      end else if (s1_q.sensor < SensorW'(SensorCount)) begin
        s2_vld_d = 1'b1;
        case (phase_q[s1_q.sensor])
          PhIdle: begin
            if (cnt_q[s1_q.sensor] == '0) begin
              trig_d[s1_q.sensor]  = 1'b1;
              cnt_d[s1_q.sensor]   = trig_ticks_q;
              phase_d[s1_q.sensor] = PhTrig;
            end
          end
          PhTrig: begin
            if (cnt_q[s1_q.sensor] == '0) begin
              trig_d[s1_q.sensor]  = 1'b0;
              phase_d[s1_q.sensor] = PhRise;
              cnt_d[s1_q.sensor]   = echo_tmo_q;
              prior_d[s1_q.sensor] = 1'b0;
            end
          end
          PhRise: begin
            if (s1_q.echo_level && !prior_q[s1_q.sensor]) begin
              rise_d[s1_q.sensor]  = s1_q.timer_now;
              phase_d[s1_q.sensor] = PhFall;
              cnt_d[s1_q.sensor]   = echo_tmo_q;
            end else if (cnt_q[s1_q.sensor] == '0) begin
              phase_d[s1_q.sensor] = PhIdle;
              cnt_d[s1_q.sensor]   = rest_ticks_q;
            end
            prior_d[s1_q.sensor] = s1_q.echo_level;
          end
          PhFall: begin
            if (!s1_q.echo_level && prior_q[s1_q.sensor]) begin
              s2_dv_d              = 1'b1;
              s2_width_d           = s1_q.timer_now - rise_q[s1_q.sensor];
              phase_d[s1_q.sensor] = PhIdle;
              cnt_d[s1_q.sensor]   = rest_ticks_q;
            end else if (cnt_q[s1_q.sensor] == '0) begin
              phase_d[s1_q.sensor] = PhIdle;
              cnt_d[s1_q.sensor]   = rest_ticks_q;
            end
            prior_d[s1_q.sensor] = s1_q.echo_level;
          end
          default: ;
        endcase
        s2_trig_d = trig_d[s1_q.sensor];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      cnt_q    <= '0;
      prior_q  <= '0;
      trig_q   <= '0;
      rise_q   <= '0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      prior_q  <= prior_d;
      trig_q   <= trig_d;
      rise_q   <= rise_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_d) begin
      s2_id_q    <= s1_q.sensor;
      s2_trig_q  <= s2_trig_d;
      s2_dv_q    <= s2_dv_d;
      s2_width_q <= s2_width_d;
    end
  end

  // stage 3: width to cm and result register
  assign prod = (TimerW+RecipW)'(s2_width_q) * (TimerW+RecipW)'(CmRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      out_q.sensor_id      <= s2_id_q;
      out_q.trigger_level  <= s2_trig_q;
      out_q.distance_valid <= s2_dv_q;
      out_q.range_cm       <= s2_dv_q ? prod[CmShift +: DistW] : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

### verif/ultrasonic_echo_range_scanner_checker.sv
// Scoreboard for the ultrasonic echo range scanner: snoops the register port and both
// request channels, predicts each result per sensor and compares it field by field.
// Depends on uers_pkg.
`timescale 1ns / 1ps

module uers_range_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uers_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [uers_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  uers_pkg::in_req_t             in_req_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  uers_pkg::out_req_t            out_req_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            result_cnt_o,
  output int                            range_cnt_o
);
  import uers_pkg::*;

  localparam int unsigned CmDivisor = 58;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhTrig = 2'd1,
    PhRise = 2'd2,
    PhFall = 2'd3
  } ranger_phase_e;

  ranger_phase_e     phase_q     [SensorCount];
  logic [CountW-1:0] countdown_q [SensorCount];
  logic              echo_seen_q [SensorCount];
  logic [TimerW-1:0] rise_at_q   [SensorCount];
  logic              trig_q      [SensorCount];

  logic [CountW-1:0] trig_ticks;
  logic [CountW-1:0] echo_tmo;
  logic [CountW-1:0] rest_ticks;

  out_req_t report_q [$];

  function automatic bit step_ranger(input in_req_t req, output out_req_t rpt);
    int unsigned       s;
    int                i;
    logic [TimerW-1:0] width;
    rpt = '0;
    if (req.kind == KindTick) begin
      for (i = 0; i < SensorCount; i++) begin
        if (countdown_q[i] != '0) countdown_q[i] = countdown_q[i] - 1'b1;
      end
      return 1'b0;
    end
    s = req.sensor;
    if (s >= SensorCount) return 1'b0;
    case (phase_q[s])
      PhIdle: begin
        if (countdown_q[s] == '0) begin
          trig_q[s]      = 1'b1;
          countdown_q[s] = trig_ticks;
          phase_q[s]     = PhTrig;
        end
      end
      PhTrig: begin
        if (countdown_q[s] == '0) begin
          trig_q[s]      = 1'b0;
          phase_q[s]     = PhRise;
          countdown_q[s] = echo_tmo;
          echo_seen_q[s] = 1'b0;
        end
      end
      PhRise: begin
        if (req.echo_level && !echo_seen_q[s]) begin
          rise_at_q[s]   = req.timer_now;
          phase_q[s]     = PhFall;
          countdown_q[s] = echo_tmo;
        end else if (countdown_q[s] == '0) begin
          phase_q[s]     = PhIdle;
          countdown_q[s] = rest_ticks;
        end
        echo_seen_q[s] = req.echo_level;
      end
      default: begin
        if (!req.echo_level && echo_seen_q[s]) begin
          width              = req.timer_now - rise_at_q[s];
          rpt.range_cm       = DistW'(width / CmDivisor);
          rpt.distance_valid = 1'b1;
          phase_q[s]         = PhIdle;
          countdown_q[s]     = rest_ticks;
        end else if (countdown_q[s] == '0) begin
          phase_q[s]     = PhIdle;
          countdown_q[s] = rest_ticks;
        end
        echo_seen_q[s] = req.echo_level;
      end
    endcase
    rpt.sensor_id     = req.sensor;
    rpt.trigger_level = trig_q[s];
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : ranger_watch
    out_req_t want;
    out_req_t rpt;
    int       i;
    if (!rst_ni) begin
      for (i = 0; i < SensorCount; i++) begin
        phase_q[i]     = PhIdle;
        countdown_q[i] = '0;
        echo_seen_q[i] = 1'b0;
        rise_at_q[i]   = '0;
        trig_q[i]      = 1'b0;
      end
      trig_ticks = TrigTicksRst;
      echo_tmo   = EchoTmoRst;
      rest_ticks = RestTicksRst;
      report_q.delete();
      fail_cnt_o   = 0;
      result_cnt_o = 0;
      range_cnt_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTrigTicks: trig_ticks = cfg_data_i;
          CfgEchoTmo:   echo_tmo   = cfg_data_i;
          CfgRestTicks: rest_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        result_cnt_o++;
        if (out_req_i.distance_valid === 1'b1) range_cnt_o++;
        if (report_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: unexpected result id=%0d trig=%0d dv=%0d cm=%0d", $time,
                     out_req_i.sensor_id, out_req_i.trigger_level,
                     out_req_i.distance_valid, out_req_i.range_cm);
        end else begin
          want = report_q.pop_front();
          if (out_req_i.sensor_id !== want.sensor_id ||
              out_req_i.trigger_level !== want.trigger_level ||
              out_req_i.distance_valid !== want.distance_valid ||
              out_req_i.range_cm !== want.range_cm) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10) begin
              $display("%0t: mismatch want id=%0d trig=%0d dv=%0d cm=%0d,",
                       $time, want.sensor_id, want.trigger_level, want.distance_valid,
                       want.range_cm);
              $display("    got id=%0d trig=%0d dv=%0d cm=%0d",
                       out_req_i.sensor_id, out_req_i.trigger_level,
                       out_req_i.distance_valid, out_req_i.range_cm);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (step_ranger(in_req_i, rpt)) report_q.push_back(rpt);
      end
    end
    pending_o = report_q.size();
  end

endmodule

### verif/ultrasonic_echo_range_scanner_unit_test.sv
// Top of the range scanner regression: clock, reset, register settings and request
// stimulus with random gaps and output stalls; verdict from uers_range_checker.
// Depends on uers_pkg, ultrasonic_echo_range_scanner_unit and uers_range_checker.
`timescale 1ns / 1ps

module ultrasonic_echo_range_scanner_unit_test;
  import uers_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 12;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CountW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  in_req_t            in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_req_t           out_req_o;

  int                 fail_cnt;
  int                 pending;
  int                 result_cnt;
  int                 range_cnt;
  int unsigned        n_reqs = 0;
  int unsigned        idle_cycles = 0;
  bit                 gaps_on;
  bit                 stall_on;
  logic [TimerW-1:0]  clock_us;
  logic               echo_pat [SensorCount];

  ultrasonic_echo_range_scanner_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  uers_range_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_i    (out_req_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .result_cnt_o (result_cnt),
    .range_cnt_o  (range_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= stall_on && ($urandom_range(0, 99) < 31);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no request moved for %0d cycles", StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input in_req_t req);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_reqs++;
  endtask

  task automatic send_poll(input int unsigned s, input logic echo, input logic [TimerW-1:0] t);
    in_req_t req;
    req.kind       = KindPoll;
    req.sensor     = SensorW'(s);
    req.echo_level = echo;
    req.timer_now  = t;
    push_req(req);
  endtask

  // ignored fields of a tick carry noise
  task automatic send_tick();
    in_req_t req;
    req      = $bits(in_req_t)'($urandom);
    req.kind = KindTick;
    push_req(req);
  endtask

  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CountW-1:0] trig, input logic [CountW-1:0] tmo,
                          input logic [CountW-1:0] rest);
    drain(SettleCycles);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTrigTicks;
    cfg_data_i <= trig;
    @(posedge clk_i);
    cfg_idx_i  <= CfgEchoTmo;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i  <= CfgRestTicks;
    cfg_data_i <= rest;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // per-sensor echo pulses mixed with ticks at tick_pct, so sequences reach the ranging phases
  task automatic run_phase(input int unsigned n_items, input int unsigned tick_pct);
    int unsigned done;
    int unsigned roll;
    int unsigned s;
    logic        echo;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) clock_us += TimerW'($urandom);
      else clock_us += TimerW'($urandom_range(1, 600));
      if (roll < tick_pct) begin
        send_tick();
        done++;
      end else if (roll < tick_pct + 4) begin
        send_poll($urandom_range(SensorCount, 15), 1'($urandom_range(0, 1)), clock_us);
      end else begin
        s = $urandom_range(0, SensorCount - 1);
        if ($urandom_range(0, 99) < 85) begin
          if ($urandom_range(0, 99) < 35) echo_pat[s] = ~echo_pat[s];
          echo = echo_pat[s];
        end else begin
          echo = 1'($urandom_range(0, 1));
        end
        send_poll(s, echo, clock_us);
        done++;
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgTrigTicks;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    clock_us = '0;
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    foreach (echo_pat[i]) echo_pat[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default registers: full sequence, widest pulse across timer wrap
    send_poll(0, 1'b1, 16'h0000);
    send_poll(0, 1'b0, 16'h0000);
    send_tick();
    send_poll(0, 1'b1, 16'h0000);
    send_poll(0, 1'b1, 16'hFFF0);
    send_poll(0, 1'b1, 16'h0100);
    send_poll(0, 1'b0, 16'hFFEF);
    // zero-width pulse and out-of-range sensors
    send_poll(9, 1'b0, 16'h0000);
    send_poll(15, 1'b1, 16'hFFFF);
    send_poll(10, 1'b0, 16'h0000);
    send_tick();
    send_poll(9, 1'b0, 16'h0010);
    send_poll(9, 1'b1, 16'h1000);
    send_poll(9, 1'b0, 16'h1000);
    send_poll(9, 1'b1, 16'h2000);
    // one-cm boundary
    send_poll(1, 1'b0, 16'h0000);
    send_tick();
    send_poll(1, 1'b0, 16'h0000);
    send_poll(1, 1'b1, 16'd200);
    send_poll(1, 1'b0, 16'd258);

    set_regs(8'd0, 8'd0, 8'd0);
    run_phase(250, 20);
    set_regs(8'd255, 8'd255, 8'd255);
    run_phase(450, 75);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_regs(8'd2, 8'd20, 8'd3);
    run_phase(250, 25);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    set_regs(8'd1, 8'd8, 8'd0);
    run_phase(200, 40);
    set_regs(CountW'($urandom_range(1, 6)), CountW'($urandom_range(5, 60)),
             CountW'($urandom_range(0, 15)));
    run_phase(200, 25);
    drain(20);

    $display("Ran %0d requests over six register settings, zero and full-scale included.",
             n_reqs);
    $display("Checked %0d poll results, %0d of them completed distance readings.",
             result_cnt, range_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/uers_pkg.sv
hw/rtl/ultrasonic_echo_range_scanner_unit.sv
verif/ultrasonic_echo_range_scanner_checker.sv
verif/ultrasonic_echo_range_scanner_unit_test.sv
